// ===== design/bta_pkg.sv =====
package bta_pkg;

  typedef enum logic [1:0] {
    OP_MODE = 2'd0,
    OP_UP   = 2'd1,
    OP_DOWN = 2'd2,
    OP_LOAD = 2'd3
  } op_t;

  // clock register addresses
  localparam logic [2:0] ADDR_SEC   = 3'd0;
  localparam logic [2:0] ADDR_MIN   = 3'd1;
  localparam logic [2:0] ADDR_HOUR  = 3'd2;
  localparam logic [2:0] ADDR_WDAY  = 3'd3;
  localparam logic [2:0] ADDR_DATE  = 3'd4;
  localparam logic [2:0] ADDR_MONTH = 3'd5;
  localparam logic [2:0] ADDR_YEAR  = 3'd6;

  // modes
  localparam logic [3:0] MODE_RUN   = 4'd0;
  localparam logic [3:0] MODE_HOUR  = 4'd1;
  localparam logic [3:0] MODE_MIN   = 4'd2;
  localparam logic [3:0] MODE_SEC   = 4'd3;
  localparam logic [3:0] MODE_DATE  = 4'd4;
  localparam logic [3:0] MODE_MONTH = 4'd5;
  localparam logic [3:0] MODE_YEAR  = 4'd6;
  localparam logic [3:0] MODE_WDAY  = 4'd7;
  localparam logic [3:0] MODE_INFO  = 4'd8;

  // field limits
  localparam logic [7:0] SEC_MAX   = 8'h59;
  localparam logic [7:0] HOUR_MAX  = 8'h23;
  localparam logic [7:0] YEAR_MAX  = 8'h99;
  localparam logic [7:0] DATE_MAX  = 8'h31;
  localparam logic [7:0] MONTH_MAX = 8'h12;
  localparam logic [7:0] BCD_ZERO  = 8'h00;
  localparam logic [7:0] BCD_ONE   = 8'h01;
  localparam logic [3:0] WDAY_MIN  = 4'd2;
  localparam logic [3:0] WDAY_MAX  = 4'd8;

  typedef struct packed {
    logic       write_valid;
    logic [2:0] write_address;
    logic [7:0] write_data;
    logic [3:0] mode;
    logic       display_select;
    logic       clear_display;
    logic       adjust_activity;
  } res_t;

  // nibbles as tens*10+units, +/-1 mod 256, then back to nibbles.
  // x/10 == (x*205)>>11 for any 8-bit x.
  function automatic logic [7:0] bcd_step(input logic [7:0] v, input logic down);
    logic [7:0]  bin;
    logic [15:0] prod;
    logic [4:0]  q;
    logic [7:0]  r;
    bin  = ({4'b0, v[7:4]} << 3) + ({4'b0, v[7:4]} << 1) + {4'b0, v[3:0]};
    bin  = down ? bin - 8'd1 : bin + 8'd1;
    prod = {8'b0, bin} * 16'd205;
    q    = prod[15:11];
    r    = bin - ({3'b0, q} << 3) - ({3'b0, q} << 1);
    return {q[3:0], r[3:0]};
  endfunction

  function automatic logic [7:0] step_field(input logic [7:0] v, input logic down,
                                            input logic [7:0] lo, input logic [7:0] hi);
    if (!down) return (v == hi) ? lo : bcd_step(v, 1'b0);
    return (v == lo) ? hi : bcd_step(v, 1'b1);
  endfunction

endpackage

// ===== design/bta_if.sv =====
interface bta_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [2:0] field_index;
  logic [7:0] field_value;

  modport source (output valid, operation, field_index, field_value, input ready);
  modport sink   (input valid, operation, field_index, field_value, output ready);
endinterface

interface bta_out_if;
  logic       valid;
  logic       ready;
  logic       write_valid;
  logic [2:0] write_address;
  logic [7:0] write_data;
  logic [3:0] mode;
  logic       display_select;
  logic       clear_display;
  logic       adjust_activity;

  modport source (output valid, write_valid, write_address, write_data, mode,
                  display_select, clear_display, adjust_activity, input ready);
  modport sink   (input valid, write_valid, write_address, write_data, mode,
                  display_select, clear_display, adjust_activity, output ready);
endinterface

// ===== design/bta_core.sv =====
module bta_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  bta_pkg::op_t      op,
  input  logic [2:0]        idx,
  input  logic [7:0]        val,
  output bta_pkg::res_t     res
);

  logic [3:0] mode_r, mode_nxt;
  logic [7:0] sec_r, sec_nxt;
  logic [7:0] min_r, min_nxt;
  logic [7:0] hour_r, hour_nxt;
  logic [3:0] wday_r, wday_nxt;
  logic [7:0] date_r, date_nxt;
  logic [7:0] month_r, month_nxt;
  logic [7:0] year_r, year_nxt;
  logic       disp_r, disp_nxt;
  logic [3:0] mode_inc;
  logic       down;

  assign mode_inc = mode_r + 4'd1;
  assign down     = (op == bta_pkg::OP_DOWN);

  always_comb begin
    mode_nxt  = mode_r;
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hour_nxt  = hour_r;
    wday_nxt  = wday_r;
    date_nxt  = date_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    disp_nxt  = disp_r;
    res       = '0;
    unique case (op)
      bta_pkg::OP_MODE: begin
        mode_nxt = mode_inc;
        if (mode_inc == bta_pkg::MODE_INFO) res.clear_display = 1'b1;
        if (mode_inc > bta_pkg::MODE_INFO) begin
          mode_nxt          = bta_pkg::MODE_RUN;
          res.clear_display = 1'b1;
        end
      end
      bta_pkg::OP_UP, bta_pkg::OP_DOWN: begin
        if (mode_r == bta_pkg::MODE_RUN) begin
          disp_nxt = !down;
        end else begin
          res.adjust_activity = 1'b1;
          unique case (mode_r)
            bta_pkg::MODE_HOUR: begin
              hour_nxt = bta_pkg::step_field(hour_r, down, bta_pkg::BCD_ZERO,
                                             bta_pkg::HOUR_MAX);
              res.write_valid   = 1'b1;
              res.write_address = bta_pkg::ADDR_HOUR;
              res.write_data    = hour_nxt;
            end
            bta_pkg::MODE_MIN: begin
              min_nxt = bta_pkg::step_field(min_r, down, bta_pkg::BCD_ZERO,
                                            bta_pkg::SEC_MAX);
              res.write_valid   = 1'b1;
              res.write_address = bta_pkg::ADDR_MIN;
              res.write_data    = min_nxt;
            end
            bta_pkg::MODE_SEC: begin
              sec_nxt = bta_pkg::step_field(sec_r, down, bta_pkg::BCD_ZERO,
                                            bta_pkg::SEC_MAX);
              res.write_valid   = 1'b1;
              res.write_address = bta_pkg::ADDR_SEC;
              res.write_data    = sec_nxt;
            end
            bta_pkg::MODE_DATE: begin
              date_nxt = bta_pkg::step_field(date_r, down, bta_pkg::BCD_ONE,
                                             bta_pkg::DATE_MAX);
              res.write_valid   = 1'b1;
              res.write_address = bta_pkg::ADDR_DATE;
              res.write_data    = date_nxt;
            end
            bta_pkg::MODE_MONTH: begin
              month_nxt = bta_pkg::step_field(month_r, down, bta_pkg::BCD_ONE,
                                              bta_pkg::MONTH_MAX);
              res.write_valid   = 1'b1;
              res.write_address = bta_pkg::ADDR_MONTH;
              res.write_data    = month_nxt;
            end
            bta_pkg::MODE_YEAR: begin
              year_nxt = bta_pkg::step_field(year_r, down, bta_pkg::BCD_ZERO,
                                             bta_pkg::YEAR_MAX);
              res.write_valid   = 1'b1;
              res.write_address = bta_pkg::ADDR_YEAR;
              res.write_data    = year_nxt;
            end
            bta_pkg::MODE_WDAY: begin
              // plain count, wraps 8 <-> 2, otherwise mod 16
              if (!down)
                wday_nxt = (wday_r == bta_pkg::WDAY_MAX) ? bta_pkg::WDAY_MIN
                                                          : wday_r + 4'd1;
              else
                wday_nxt = (wday_r == bta_pkg::WDAY_MIN) ? bta_pkg::WDAY_MAX
                                                          : wday_r - 4'd1;
              res.write_valid   = 1'b1;
              res.write_address = bta_pkg::ADDR_WDAY;
              res.write_data    = {4'b0, wday_nxt};
            end
            default: ;  // info mode: activity only
          endcase
        end
      end
      bta_pkg::OP_LOAD: begin
        unique case (idx)
          bta_pkg::ADDR_SEC:   sec_nxt   = val;
          bta_pkg::ADDR_MIN:   min_nxt   = val;
          bta_pkg::ADDR_HOUR:  hour_nxt  = val;
          bta_pkg::ADDR_WDAY:  wday_nxt  = val[3:0];
          bta_pkg::ADDR_DATE:  date_nxt  = val;
          bta_pkg::ADDR_MONTH: month_nxt = val;
          bta_pkg::ADDR_YEAR:  year_nxt  = val;
          default: ;
        endcase
      end
      default: ;
    endcase
    res.mode           = mode_nxt;
    res.display_select = disp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= bta_pkg::MODE_RUN;
      sec_r   <= bta_pkg::BCD_ZERO;
      min_r   <= bta_pkg::BCD_ZERO;
      hour_r  <= bta_pkg::BCD_ZERO;
      wday_r  <= bta_pkg::WDAY_MIN;
      date_r  <= bta_pkg::BCD_ONE;
      month_r <= bta_pkg::BCD_ONE;
      year_r  <= bta_pkg::BCD_ZERO;
      disp_r  <= 1'b1;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      sec_r   <= sec_nxt;
      min_r   <= min_nxt;
      hour_r  <= hour_nxt;
      wday_r  <= wday_nxt;
      date_r  <= date_nxt;
      month_r <= month_nxt;
      year_r  <= year_nxt;
      disp_r  <= disp_nxt;
    end
  end

endmodule

// ===== design/bta_obuf.sv =====
// two-entry output buffer: result register plus skid register
module bta_obuf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bta_pkg::res_t push_data,
  output logic          can_push,
  output logic          out_valid,
  input  logic          out_ready,
  output bta_pkg::res_t out_data
);

  logic          main_valid_r, skid_valid_r;
  bta_pkg::res_t main_r, skid_r;
  logic          pop;

  assign pop       = main_valid_r && out_ready;
  assign can_push  = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        main_r       <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_r       <= push_data;
        main_valid_r <= 1'b1;
      end else begin
        skid_r       <= push_data;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      main_valid_r <= 1'b0;
    end
  end

endmodule

// ===== design/bcd_time_field_adjuster_unit.sv =====
// Time-setting controller for a real-time clock, driven by key words.
// Each input word is a mode key, an up key, a down key or a load of one
// field from a clock read; each gives exactly one result word with the
// mode after the key, the display flag, a clear-display strobe, an
// activity strobe, and (in modes 1..7 on up/down) a clock register write
// of the stepped BCD field. One word is taken every cycle while input
// ready is high, and each result is registered in the output buffer.
// The step logic is combinational from the accepted word and the field
// registers to the output buffer; a two-entry output buffer lets one
// more word in while a result is stalled, so input ready drops only when both entries are full.
module bcd_time_field_adjuster_unit (
  input  logic             clk,
  input  logic             rst_n,
  bta_in_if.sink           in_ch,
  bta_out_if.source        out_ch
);

  logic          accept;
  logic          can_push;
  bta_pkg::res_t step_res;
  bta_pkg::res_t out_res;

  assign in_ch.ready = can_push;
  assign accept      = in_ch.valid && can_push;

  // field registers and step logic
  bta_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .op     (bta_pkg::op_t'(in_ch.operation)),
    .idx    (in_ch.field_index),
    .val    (in_ch.field_value),
    .res    (step_res)
  );

  // result register with skid entry
  bta_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (step_res),
    .can_push  (can_push),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_res)
  );

  assign out_ch.write_valid     = out_res.write_valid;
  assign out_ch.write_address   = out_res.write_address;
  assign out_ch.write_data      = out_res.write_data;
  assign out_ch.mode            = out_res.mode;
  assign out_ch.display_select  = out_res.display_select;
  assign out_ch.clear_display   = out_res.clear_display;
  assign out_ch.adjust_activity = out_res.adjust_activity;

endmodule

// ===== design/bta_checker.sv =====
module bta_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       write_valid,
  input logic [2:0] write_address,
  input logic [7:0] write_data,
  input logic [3:0] mode,
  input logic       clear_display,
  input logic       adjust_activity
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(write_data) && $stable(mode))
    else $error("stalled result changed");

  a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !write_valid |-> write_address == 3'd0 && write_data == 8'd0)
    else $error("write fields set without write");

  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> mode <= bta_pkg::MODE_INFO)
    else $error("mode out of range");

  a_clear_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && clear_display |->
      (mode == bta_pkg::MODE_RUN || mode == bta_pkg::MODE_INFO) && !adjust_activity)
    else $error("clear strobe in wrong mode");

  a_write_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && write_valid |->
      adjust_activity && mode != bta_pkg::MODE_RUN && mode != bta_pkg::MODE_INFO)
    else $error("write outside adjust modes");

endmodule

bind bcd_time_field_adjuster_unit bta_checker u_bta_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .write_valid     (out_ch.write_valid),
  .write_address   (out_ch.write_address),
  .write_data      (out_ch.write_data),
  .mode            (out_ch.mode),
  .clear_display   (out_ch.clear_display),
  .adjust_activity (out_ch.adjust_activity)
);
